FILE: design/fbpa_pkg.sv
package fbpa_pkg;

   localparam int MAX_SLOTS    = 64;
   localparam int HEADER_BYTES = 16;

   localparam int SLOT_IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int COUNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int ADDR_W      = 32;
   localparam int UNIT_W      = 13;
   localparam int SLOT_CNT_W  = 7;
   localparam int STRIDE_W    = 14;
   localparam int PROD_W      = SLOT_IDX_W + STRIDE_W;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_STEPS   = ADDR_W;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

   localparam logic [ADDR_W-1:0]     POOL_BASE_RESET  = '0;
   localparam logic [UNIT_W-1:0]     UNIT_SIZE_RESET  = 13'd4;
   localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RESET = 7'd5;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_POOL_BASE  = 2'd0;
   localparam csr_index_type CSR_UNIT_SIZE  = 2'd1;
   localparam csr_index_type CSR_SLOT_COUNT = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED   = 3'd0,
      ST_EXHAUSTED   = 3'd1,
      ST_FREED       = 3'd2,
      ST_INVALID     = 3'd3,
      ST_DOUBLE_FREE = 3'd4
   } status_type;

   typedef struct packed {
      logic capture;
      logic pop;
      logic grant;
      logic div_start;
      logic check;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } dp_status_type;

   function automatic logic [COUNT_W-1:0] eff_count(input logic [SLOT_CNT_W-1:0] sc);
      logic [COUNT_W-1:0] result;
      if (32'(sc) > 32'(MAX_SLOTS)) begin
         result = COUNT_W'(MAX_SLOTS);
      end else begin
         result = COUNT_W'(sc);
      end
      return result;
   endfunction

endpackage

FILE: design/fbpa_req_if.sv
interface fbpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [fbpa_pkg::ADDR_W-1:0] free_address;

   modport source (output valid, output mode, output free_address, input ready);
   modport sink   (input valid, input mode, input free_address, output ready);
endinterface

FILE: design/fbpa_rsp_if.sv
interface fbpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbpa_pkg::STATUS_W-1:0] status;
   logic [fbpa_pkg::ADDR_W-1:0]   granted_address;

   modport source (output valid, output status, output granted_address, input ready);
   modport sink   (input valid, input status, input granted_address, output ready);
endinterface

FILE: design/fbpa_ram.sv
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             write_enable,
   input  logic [$clog2(DEPTH)-1:0]         write_address,
   input  logic [WIDTH-1:0]                 write_data,
   input  logic                             read_enable,
   input  logic [$clog2(DEPTH)-1:0]         read_address,
   output logic [WIDTH-1:0]                 read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

FILE: design/fbpa_divider.sv
module fbpa_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
   input  logic [fbpa_pkg::STRIDE_W-1:0] divisor,
   output logic                          done,
   output logic [fbpa_pkg::ADDR_W-1:0]   quotient,
   output logic [fbpa_pkg::STRIDE_W-1:0] remainder
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [fbpa_pkg::DIV_COUNT_W-1:0] count_ff, count_in;
   logic [fbpa_pkg::STRIDE_W-1:0]    rem_ff, rem_in;
   logic [fbpa_pkg::ADDR_W-1:0]      quo_ff, quo_in;
   logic [fbpa_pkg::STRIDE_W:0]      trial;
   logic                             fits;

   assign trial = {rem_ff, quo_ff[fbpa_pkg::ADDR_W-1]};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (fits) begin
            rem_in = fbpa_pkg::STRIDE_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[fbpa_pkg::STRIDE_W-1:0];
         end
         quo_in   = {quo_ff[fbpa_pkg::ADDR_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == fbpa_pkg::DIV_COUNT_W'(fbpa_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/fbpa_datapath.sv
module fbpa_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fbpa_pkg::dp_cmd_type                 cmd,
   output fbpa_pkg::dp_status_type              stat,
   input  logic                                 req_mode,
   input  logic [fbpa_pkg::ADDR_W-1:0]          req_free_address,
   input  logic                                 csr_write_enable,
   input  fbpa_pkg::csr_index_type              csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fbpa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]          rsp_granted_address
);

   localparam int IW = fbpa_pkg::SLOT_IDX_W;
   localparam int CW = fbpa_pkg::COUNT_W;

   logic [fbpa_pkg::ADDR_W-1:0]     pool_base_ff, pool_base_in;
   logic [fbpa_pkg::UNIT_W-1:0]     unit_size_ff, unit_size_in;
   logic [fbpa_pkg::SLOT_CNT_W-1:0] slot_count_ff, slot_count_in;
   logic [fbpa_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic                            mode_ff, mode_in;
   logic [CW-1:0]                   depth_ff, depth_in;
   logic [CW-1:0]                   fresh_ff, fresh_in;
   logic [fbpa_pkg::MAX_SLOTS-1:0]  in_use_ff, in_use_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic                            ok_ff, ok_in;
   logic                            from_stack_ff, from_stack_in;
   logic [fbpa_pkg::PROD_W-1:0]     prod_ff, prod_in;
   fbpa_pkg::status_type            status_ff, status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fbpa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [fbpa_pkg::ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;

   logic                            reinit;
   logic [fbpa_pkg::STRIDE_W-1:0]   stride;
   logic [fbpa_pkg::ADDR_W-1:0]     offset;
   logic [IW-1:0]                   grant_idx;
   logic [IW-1:0]                   free_idx;
   logic                            free_ok;

   logic                            ram_we, ram_re;
   logic [IW-1:0]                   ram_waddr, ram_raddr;
   logic [IW-1:0]                   ram_rdata;

   logic                            div_done;
   logic [fbpa_pkg::ADDR_W-1:0]     div_quo;
   logic [fbpa_pkg::STRIDE_W-1:0]   div_rem;

   assign stride = fbpa_pkg::STRIDE_W'(unit_size_ff) +
                   fbpa_pkg::STRIDE_W'(fbpa_pkg::HEADER_BYTES);
   assign offset = addr_ff - pool_base_ff - fbpa_pkg::ADDR_W'(fbpa_pkg::HEADER_BYTES);
   assign grant_idx = from_stack_ff ? ram_rdata : idx_ff;
   assign free_idx  = div_quo[IW-1:0];
   assign free_ok   = (div_rem == '0) &&
                      (div_quo < fbpa_pkg::ADDR_W'(fbpa_pkg::eff_count(slot_count_ff)));

   fbpa_ram #(
      .WIDTH (IW),
      .DEPTH (fbpa_pkg::MAX_SLOTS)
   ) u_stack (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (free_idx),
      .read_enable   (ram_re),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   fbpa_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (offset),
      .divisor   (stride),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      pool_base_in  = pool_base_ff;
      unit_size_in  = unit_size_ff;
      slot_count_in = slot_count_ff;
      addr_in       = addr_ff;
      mode_in       = mode_ff;
      depth_in      = depth_ff;
      fresh_in      = fresh_ff;
      in_use_in     = in_use_ff;
      idx_in        = idx_ff;
      ok_in         = ok_ff;
      from_stack_in = from_stack_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = depth_ff[IW-1:0];
      ram_raddr     = IW'(depth_ff - 1'b1);
      reinit        = 1'b0;

      if (csr_write_enable) begin
         reinit = csr_index inside {fbpa_pkg::CSR_POOL_BASE, fbpa_pkg::CSR_UNIT_SIZE,
                                    fbpa_pkg::CSR_SLOT_COUNT};
         case (csr_index)
            fbpa_pkg::CSR_POOL_BASE: begin
               pool_base_in = csr_write_data;
            end
            fbpa_pkg::CSR_UNIT_SIZE: begin
               unit_size_in = csr_write_data[fbpa_pkg::UNIT_W-1:0];
            end
            fbpa_pkg::CSR_SLOT_COUNT: begin
               slot_count_in = csr_write_data[fbpa_pkg::SLOT_CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         mode_in = req_mode;
         addr_in = req_free_address;
      end

      if (cmd.pop) begin
         if (depth_ff != '0) begin
            depth_in      = depth_ff - 1'b1;
            ram_re        = 1'b1;
            from_stack_in = 1'b1;
            ok_in         = 1'b1;
         end else if (fresh_ff != '0) begin
            fresh_in      = fresh_ff - 1'b1;
            idx_in        = IW'(fresh_ff - 1'b1);
            from_stack_in = 1'b0;
            ok_in         = 1'b1;
         end else begin
            from_stack_in = 1'b0;
            ok_in         = 1'b0;
         end
      end

      if (cmd.grant) begin
         idx_in  = grant_idx;
         prod_in = fbpa_pkg::PROD_W'(grant_idx) * fbpa_pkg::PROD_W'(stride);
         if (ok_ff) begin
            in_use_in[grant_idx] = 1'b1;
            status_in = fbpa_pkg::ST_ALLOCATED;
         end else begin
            status_in = fbpa_pkg::ST_EXHAUSTED;
         end
      end

      if (cmd.check) begin
         if (!free_ok) begin
            status_in = fbpa_pkg::ST_INVALID;
         end else if (!in_use_ff[free_idx]) begin
            status_in = fbpa_pkg::ST_DOUBLE_FREE;
         end else begin
            in_use_in[free_idx] = 1'b0;
            if (depth_ff < CW'(fbpa_pkg::MAX_SLOTS)) begin
               ram_we   = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
            status_in = fbpa_pkg::ST_FREED;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         if (!mode_ff && status_ff == fbpa_pkg::ST_ALLOCATED) begin
            rsp_addr_in = pool_base_ff + fbpa_pkg::ADDR_W'(prod_ff) +
                          fbpa_pkg::ADDR_W'(fbpa_pkg::HEADER_BYTES);
         end else begin
            rsp_addr_in = '0;
         end
      end

      if (reinit) begin
         depth_in  = '0;
         in_use_in = '0;
         fresh_in  = fbpa_pkg::eff_count(slot_count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= fbpa_pkg::POOL_BASE_RESET;
         unit_size_ff  <= fbpa_pkg::UNIT_SIZE_RESET;
         slot_count_ff <= fbpa_pkg::SLOT_COUNT_RESET;
         depth_ff      <= '0;
         fresh_ff      <= fbpa_pkg::eff_count(fbpa_pkg::SLOT_COUNT_RESET);
         in_use_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pool_base_ff  <= pool_base_in;
         unit_size_ff  <= unit_size_in;
         slot_count_ff <= slot_count_in;
         depth_ff      <= depth_in;
         fresh_ff      <= fresh_in;
         in_use_ff     <= in_use_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      ok_ff         <= ok_in;
      from_stack_ff <= from_stack_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign stat.div_done       = div_done;
   assign stat.rsp_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;

endmodule

FILE: design/fbpa_ctrl.sv
module fbpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_ready,
   input  fbpa_pkg::dp_status_type stat,
   output fbpa_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      ALLOC_POP,
      ALLOC_GRANT,
      FREE_START,
      FREE_DIV,
      FREE_CHECK,
      DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_mode ? FREE_START : ALLOC_POP;
            end
         end
         ALLOC_POP: begin
            cmd.pop  = 1'b1;
            state_in = ALLOC_GRANT;
         end
         ALLOC_GRANT: begin
            cmd.grant = 1'b1;
            state_in  = DONE;
         end
         FREE_START: begin
            cmd.div_start = 1'b1;
            state_in      = FREE_DIV;
         end
         FREE_DIV: begin
            if (stat.div_done) begin
               state_in = FREE_CHECK;
            end
         end
         FREE_CHECK: begin
            cmd.check = 1'b1;
            state_in  = DONE;
         end
         DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == IDLE);

endmodule

FILE: design/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator. Slots of HEADER_BYTES header plus unit_size payload bytes
// are laid out from pool_base; an alloc request pops the most recently freed slot (or else
// the highest slot never handed out) and returns its payload address, a free request checks
// the address and pushes the slot back. Each request gives exactly one response. An alloc
// request passes through ALLOC_POP and ALLOC_GRANT, a free request through FREE_START,
// FREE_DIV, where the bit-serial divider works out the slot index, one quotient bit per
// cycle, and FREE_CHECK; both then wait in DONE until the output register can take the
// response. One request is in work at a time, and the next one is accepted while a response
// still waits in the output register. A write to any of the three configuration registers
// frees every slot and restarts the pool; a write to an unused index is ignored.
module fixed_block_pool_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   fbpa_req_if.sink                        req,
   fbpa_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0] csr_write_data
);

   fbpa_pkg::dp_cmd_type    cmd;
   fbpa_pkg::dp_status_type stat;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbpa_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req.mode),
      .req_free_address    (req.free_address),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp.valid),
      .rsp_ready           (rsp.ready),
      .rsp_status          (rsp.status),
      .rsp_granted_address (rsp.granted_address)
   );

endmodule
